@@ sv/tgf_pkg.sv @@
// Package for the grouped FIFO: widths, op and status codes, payload structs.
// No dependencies.
package tgf_pkg;
    localparam int ElemBits = 10;
    localparam int TeamBits = 4;
    localparam int Teams    = 16;
    localparam int SlotBits = 8;
    localparam int Capacity = 256;
    localparam int ValCount = 1 << ElemBits;

    typedef enum logic [1:0] {
        OP_ASSIGN  = 2'd0,
        OP_ENQUEUE = 2'd1,
        OP_DEQUEUE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]          op;
        logic [ElemBits-1:0] value;
        logic [TeamBits-1:0] team_id;
    } t_in_item;

    typedef struct packed {
        logic [ElemBits-1:0] out_value;
        logic [TeamBits-1:0] out_team;
        logic [1:0]          status;
    } t_out_item;
endpackage

@@ sv/tgf_in_if.sv @@
// Input channel interface for the grouped FIFO.
// Depends on tgf_pkg.
interface tgf_in_if import tgf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/tgf_out_if.sv @@
// Result channel interface for the grouped FIFO.
// Depends on tgf_pkg.
interface tgf_out_if import tgf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/team_grouped_fifo_top.sv @@
// Grouped FIFO (team queue). Every item passes the same steps: the
// accepting state, two memory read states (membership, free-stack top, and
// the order ring front with its group head slot), one write-back state that
// also loads the result data, and a done state that marks the result valid.
// The block holds one item at a time. After reset, and after a clear, a
// sweep over all 1024 membership entries zeroes the membership memory and
// rebuilds the free stack before the next item is taken. The result sits in
// an output register. A new item is taken only when that register is empty,
// or when its result is transferred in the same cycle.
// Depends on tgf_pkg, tgf_in_if and tgf_out_if.
module team_grouped_fifo_top import tgf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tgf_in_if.sink   i_in,
    tgf_out_if.source o_out
);
    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_READ1, S_READ2, S_WRITE, S_DONE
    } t_state;

    // Memories, all with registered reads.
    logic [TeamBits-1:0] mem_member [ValCount];
    logic [ElemBits-1:0] mem_sval   [Capacity];
    logic [SlotBits-1:0] mem_snext  [Capacity];
    logic [SlotBits-1:0] mem_free   [Capacity];
    logic [SlotBits-1:0] r_ghead [Teams];
    logic [SlotBits-1:0] r_gtail [Teams];
    logic [TeamBits-1:0] r_ring  [Teams];
    logic [Teams-1:0]    r_busy;

    t_state              r_state;
    t_in_item            r_item;
    logic [ElemBits-1:0] r_sweep;
    logic [TeamBits-1:0] r_front, r_back;
    logic [TeamBits:0]   r_ocount;
    logic [SlotBits:0]   r_fcount;
    logic [TeamBits-1:0] r_team;
    logic [SlotBits-1:0] r_slot;
    logic                r_ovalid;
    t_out_item           r_odata;

    // Read data registers.
    logic [TeamBits-1:0] r_rd_member;
    logic [ElemBits-1:0] r_rd_sval;
    logic [SlotBits-1:0] r_rd_snext;
    logic [SlotBits-1:0] r_rd_free;

    // Read addresses.
    logic [ElemBits-1:0] n_member_addr;
    logic [SlotBits-1:0] n_slot_addr;
    logic [SlotBits-1:0] n_free_addr;
    logic [TeamBits-1:0] n_team;

    // Result of the item in write-back.
    t_out_item           n_odata;

    logic accept;
    assign i_in.ready   = (r_state == S_IDLE) && (!r_ovalid || o_out.ready);
    assign accept       = i_in.valid && i_in.ready;
    assign o_out.valid  = r_ovalid;
    assign o_out.data   = r_odata;

    // Dequeue target team comes from the order ring front.
    always_comb begin
        n_team        = r_ring[r_front];
        n_member_addr = r_item.value;
        n_slot_addr   = r_ghead[n_team];
        n_free_addr   = SlotBits'(r_fcount - 1'b1);
    end

    // The result fields are zero except for a status code or a dequeued element.
    always_comb begin
        n_odata = '0;
        case (t_op'(r_item.op))
            OP_ENQUEUE: begin
                if (r_fcount == '0) n_odata.status = ST_FULL;
            end
            OP_DEQUEUE: begin
                if (r_ocount == '0) begin
                    n_odata.status = ST_EMPTY;
                end else begin
                    n_odata.out_value = r_rd_sval;
                    n_odata.out_team  = r_team;
                end
            end
            default: ;
        endcase
    end

    // Memory ports: one read per memory per cycle, writes in sweep/write.
    always_ff @(posedge i_clk) begin
        r_rd_member <= mem_member[n_member_addr];
        r_rd_sval   <= mem_sval[n_slot_addr];
        r_rd_snext  <= mem_snext[n_slot_addr];
        r_rd_free   <= mem_free[n_free_addr];
        if (r_state == S_SWEEP) begin
            mem_member[r_sweep] <= '0;
            mem_free[r_sweep[SlotBits-1:0]] <= SlotBits'(Capacity - 1) - r_sweep[SlotBits-1:0];
        end
        if (r_state == S_WRITE) begin
            case (t_op'(r_item.op))
                OP_ASSIGN: mem_member[r_item.value] <= r_item.team_id;
                OP_ENQUEUE: begin
                    if (r_fcount != '0) begin
                        mem_sval[r_rd_free] <= r_item.value;
                        if (r_busy[r_rd_member])
                            mem_snext[r_gtail[r_rd_member]] <= r_rd_free;
                    end
                end
                OP_DEQUEUE: begin
                    if (r_ocount != '0 && r_fcount != (SlotBits+1)'(Capacity))
                        mem_free[r_fcount[SlotBits-1:0]] <= r_slot;
                end
                default: ;
            endcase
        end
    end

    // Sequencer, pointer registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_sweep  <= '0;
            r_busy   <= '0;
            r_front  <= '0;
            r_back   <= '0;
            r_ocount <= '0;
            r_fcount <= (SlotBits+1)'(Capacity);
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == ElemBits'(ValCount - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_item  <= i_in.data;
                        r_state <= S_READ1;
                    end
                end
                S_READ1: begin
                    // Member, free-top, head slot reads now in flight.
                    r_team  <= n_team;
                    r_slot  <= n_slot_addr;
                    r_state <= S_READ2;
                end
                S_READ2: r_state <= S_WRITE;
                S_WRITE: begin
                    r_odata  <= n_odata;
                    r_state  <= S_DONE;
                    case (t_op'(r_item.op))
                        OP_ENQUEUE: begin
                            if (r_fcount != '0) begin
                                r_fcount <= r_fcount - 1'b1;
                                r_gtail[r_rd_member] <= r_rd_free;
                                if (!r_busy[r_rd_member]) begin
                                    r_busy[r_rd_member]  <= 1'b1;
                                    r_ghead[r_rd_member] <= r_rd_free;
                                    r_ring[r_back]       <= r_rd_member;
                                    r_back   <= r_back + 1'b1;
                                    r_ocount <= r_ocount + 1'b1;
                                end
                            end
                        end
                        OP_DEQUEUE: begin
                            if (r_ocount != '0) begin
                                if (r_slot == r_gtail[r_team]) begin
                                    r_busy[r_team] <= 1'b0;
                                    r_front  <= r_front + 1'b1;
                                    r_ocount <= r_ocount - 1'b1;
                                end else begin
                                    r_ghead[r_team] <= r_rd_snext;
                                end
                                if (r_fcount != (SlotBits+1)'(Capacity))
                                    r_fcount <= r_fcount + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            r_busy   <= '0;
                            r_front  <= '0;
                            r_back   <= '0;
                            r_ocount <= '0;
                            r_fcount <= (SlotBits+1)'(Capacity);
                            r_sweep  <= '0;
                        end
                        default: ;
                    endcase
                end
                S_DONE: begin
                    r_state  <= (t_op'(r_item.op) == OP_CLEAR) ? S_SWEEP : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The order count never exceeds the number of teams.
    a_ocount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocount <= (TeamBits+1)'(Teams)) else $error("order count overflow");
    // Free count never exceeds capacity.
    a_fcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcount <= (SlotBits+1)'(Capacity)) else $error("free count overflow");
    // No item is taken during the sweep.
    a_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWEEP |-> !i_in.ready) else $error("accept during sweep");
    // An empty order means no team is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocount == '0 |-> r_busy == '0) else $error("busy team with empty order");
endmodule

@@ bench/team_grouped_fifo_top_tb.sv @@
// Testbench for the grouped FIFO: drives assign, enqueue, dequeue and clear
// transfers, predicts each result with a scoreboard model and checks it.
// Depends on tgf_pkg, tgf_in_if, tgf_out_if and team_grouped_fifo_top.
`timescale 1ns / 1ps

module team_grouped_fifo_top_tb import tgf_pkg::*; ();

    // Scoreboard: its own copy of the team queue and the expected results.
    class tgf_scoreboard;
        logic [TeamBits-1:0] team_of [ValCount];
        logic [ElemBits-1:0] group_vals [Teams][$];
        logic [TeamBits-1:0] team_order [$];
        int                  stored;
        t_out_item           pending [$];
        int                  errors;
        int                  checked;
        int                  n_empty;
        int                  n_full;

        function new();
            errors  = 0;
            checked = 0;
            n_empty = 0;
            n_full  = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (team_of[k]) team_of[k] = '0;
            foreach (group_vals[k]) group_vals[k].delete();
            team_order.delete();
            stored = 0;
        endfunction

        // Notes an accepted input transfer and queues its expected result.
        function void note_input(t_in_item it);
            t_out_item           res;
            logic [TeamBits-1:0] tm;
            res = '0;
            res.status = ST_OK;
            case (t_op'(it.op))
                OP_ASSIGN: team_of[it.value] = it.team_id;
                OP_ENQUEUE: begin
                    if (stored == Capacity) begin
                        res.status = ST_FULL;
                    end else begin
                        tm = team_of[it.value];
                        if (group_vals[tm].size() == 0) team_order.push_back(tm);
                        group_vals[tm].push_back(it.value);
                        stored++;
                    end
                end
                OP_DEQUEUE: begin
                    if (team_order.size() == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        tm = team_order[0];
                        res.out_team  = tm;
                        res.out_value = group_vals[tm].pop_front();
                        if (group_vals[tm].size() == 0) void'(team_order.pop_front());
                        stored--;
                    end
                end
                default: wipe();
            endcase
            pending.push_back(res);
        endfunction

        // Checks one result transfer against the oldest expectation.
        task check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report_error("result with nothing expected", got, '0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.status == ST_EMPTY) n_empty++;
            if (want.status == ST_FULL) n_full++;
            if (got.out_value !== want.out_value || got.out_team !== want.out_team
                || got.status !== want.status)
                report_error("field mismatch", got, want);
        endtask

        task report_error(string what, t_out_item got, t_out_item want);
            errors++;
            $display("MISMATCH %s: got v=%0d t=%0d s=%0d, want v=%0d t=%0d s=%0d",
                     what, got.out_value, got.out_team, got.status,
                     want.out_value, want.out_team, want.status);
        endtask
    endclass

    localparam int WatchLimit = 20000;

    logic i_clk;
    logic i_rst_n;
    tgf_in_if  in_ch ();
    tgf_out_if out_ch ();

    team_grouped_fifo_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    tgf_scoreboard board;
    int  sent;
    bit  hold_off;
    bit  stall_on;
    int  idle_cycles;

    initial begin
        i_clk = 1'b0;
        board = new();
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Monitor both channels at each rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) board.note_input(in_ch.data);
            if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
        end
    end

    // Receiver stalls on a pattern of its own, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            out_ch.ready <= 1'b0;
        else if (stall_on)
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        else
            out_ch.ready <= 1'b1;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit) begin
            $display("watchdog expired");
            $display("team_grouped_fifo_top_tb failed");
            $finish;
        end
    end

    // Offers one item and waits for its transfer.
    task automatic send_item(t_op op, logic [ElemBits-1:0] v, logic [TeamBits-1:0] tm);
        t_in_item it;
        it.op      = op;
        it.value   = v;
        it.team_id = tm;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic pause_sender(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drops valid, waits so the last transfer is noted, then until all results are in.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    // Picks a random item; mostly enqueue and dequeue on a small value set.
    task automatic send_random(int enq_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            send_item(OP_ASSIGN, $urandom_range(0, 1) ? ElemBits'($urandom_range(0, 31))
                      : ElemBits'($urandom_range(0, 1023)), TeamBits'($urandom_range(0, 15)));
        else if (r < 10 + enq_weight)
            send_item(OP_ENQUEUE, $urandom_range(0, 1) ? ElemBits'($urandom_range(0, 31))
                      : ElemBits'($urandom_range(0, 1023)), '0);
        else if (r < 99)
            send_item(OP_DEQUEUE, ElemBits'($urandom()), TeamBits'($urandom()));
        else
            send_item(OP_CLEAR, ElemBits'($urandom()), TeamBits'($urandom()));
    endtask

    initial begin
        int burst;
        sent        = 0;
        hold_off    = 1'b0;
        stall_on    = 1'b0;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty dequeue, extremes, team ordering, assign, clear.
        send_item(OP_DEQUEUE, '0, '0);
        send_item(OP_ASSIGN, 10'd1023, 4'd15);
        send_item(OP_ASSIGN, 10'd5, 4'd3);
        send_item(OP_ASSIGN, 10'd6, 4'd3);
        send_item(OP_ENQUEUE, 10'd0, 4'd15);
        send_item(OP_ENQUEUE, 10'd5, 4'd0);
        send_item(OP_ENQUEUE, 10'd1023, 4'd0);
        send_item(OP_ENQUEUE, 10'd7, 4'd0);
        send_item(OP_ENQUEUE, 10'd6, 4'd0);
        repeat (6) send_item(OP_DEQUEUE, 10'd1023, 4'd15);
        send_item(OP_ASSIGN, 10'd5, 4'd0);
        send_item(OP_ENQUEUE, 10'd5, 4'd0);
        send_item(OP_CLEAR, '0, '0);
        send_item(OP_ENQUEUE, 10'd1023, 4'd0);
        send_item(OP_DEQUEUE, '0, '0);

        // Fill the store past capacity; the receiver holds off at first.
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < Capacity + 3; k++)
                send_item(OP_ENQUEUE, k[ElemBits-1:0], '0);
        join
        repeat (Capacity + 3) send_item(OP_DEQUEUE, '0, '0);
        drain();

        // Random bursts with gaps; receiver stalls on its own pattern.
        stall_on = 1'b1;
        while (sent < 750) begin
            burst = $urandom_range(1, 20);
            repeat (burst) send_random(sent < 450 ? 55 : 40);
            if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 8));
            if ($urandom_range(0, 15) == 0) drain();
        end
        stall_on = 1'b0;

        drain();
        repeat (30) @(posedge i_clk);
        $display("covered %0d transfers, %0d results checked (%0d empty, %0d full)",
                 sent, board.checked, board.n_empty, board.n_full);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("team_grouped_fifo_top_tb passed");
        else
            $display("team_grouped_fifo_top_tb failed");
        $finish;
    end
endmodule
